// ===== hw/rtl/cdq_pkg.sv =====
// shared constants, types and index helpers for the circular deque
package cdq_pkg;

    localparam int CAPACITY    = 1024;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VAL_W       = 32;
    localparam int MODE_W      = 3;

    localparam int IN_W        = MODE_W + VAL_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 3 * VAL_W + CNT_W + 3;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [VAL_W-1:0] NONE_VALUE = '1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [VAL_W-1:0] t_val;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_PEEK       = 3'd4
    } t_mode;

    function automatic t_idx idx_next(t_idx i);
        return (i == IDX_W'(CAPACITY - 1)) ? '0 : t_idx'(i + 1'b1);
    endfunction

    function automatic t_idx idx_prev(t_idx i);
        return (i == '0) ? IDX_W'(CAPACITY - 1) : t_idx'(i - 1'b1);
    endfunction

endpackage

// ===== hw/rtl/cdq_ram.sv =====
// simple dual-port ram, one write and one registered read per cycle
module cdq_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/circular_deque_top.sv =====
// circular deque top level: stream ports, pointer control and result packing
//
// usage
//   input stream (s_*): one request per item, tdata = {push_value, mode}
//     mode 0 push front, 1 push back, 2 pop front, 3 pop back, 4..7 peek
//   output stream (m_*): one result per request, in request order, carrying
//     the popped value, pop/overflow flags, element count, empty flag and the
//     front and back values after the request
//   in the accept cycle a request does the pointer update and the slot write
//   or the slot read; the execute state then takes the registered ram read
//   data and loads the output register once it is free; one request is in
//   flight, so the block takes no new request before that load is done
//   front and back values live in registers; the ram holds all slots and is
//   read only to find the new front or back after a pop
//   a push into a full deque is dropped and flagged as overflow; a pop from
//   an empty deque returns -1 with pop_ok low
//   reset (i_rst_n low, synchronous) empties the deque; ram contents are not
//   cleared since a slot is only read while it holds an element
//   a stalled output holds its result; the next request is taken while the
//   result waits and stays in the execute state until the register frees up
module circular_deque_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // bits from lsb: mode[2:0], push_value[34:3], zero pad
    input  logic [cdq_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // bits from lsb: popped_value[31:0], pop_ok[32], overflow[33],
    // element_count[44:34], is_empty[45], front_value[77:46],
    // back_value[109:78], zero pad
    output logic [cdq_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import cdq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // what the execute state does to the cached front and back values
    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_PUSH_F,
        UPD_PUSH_B,
        UPD_POP_F,
        UPD_POP_B
    } t_upd;

    t_state r_state;
    t_idx   r_head, n_head;
    t_idx   r_tail, n_tail;
    t_cnt   r_count, n_count;
    t_val   r_front, n_front;
    t_val   r_back, n_back;

    // request held for the execute state
    t_upd   r_upd, n_upd;
    t_val   r_val;
    logic   r_pop_ok, n_pop_ok;
    logic   r_ovf, n_ovf;
    t_val   r_popped, n_popped;

    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;

    // ram port controls
    logic we, re;
    t_idx waddr, raddr;
    t_val rd_data;

    logic [MODE_W-1:0] in_mode;
    t_val              in_val;
    logic              accept;
    logic              exec_done;
    logic              full, empty;
    logic              out_empty;
    logic [OUT_W-1:0]  out_pack;

    assign in_mode  = s_tdata[MODE_W-1:0];
    assign in_val   = s_tdata[IN_W-1:MODE_W];
    assign s_tready = (r_state == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign empty    = (r_count == '0);

    // accept cycle: pointer update plus slot write or read
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_upd    = UPD_NONE;
        n_pop_ok = 1'b0;
        n_ovf    = 1'b0;
        n_popped = NONE_VALUE;
        we       = 1'b0;
        waddr    = r_tail;
        re       = 1'b0;
        raddr    = idx_next(r_head);
        case (in_mode)
            MODE_PUSH_FRONT: begin
                if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_head  = idx_prev(r_head);
                    we      = accept;
                    waddr   = idx_prev(r_head);
                    n_count = t_cnt'(r_count + 1'b1);
                    n_upd   = UPD_PUSH_F;
                end
            end
            MODE_PUSH_BACK: begin
                if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_tail  = idx_next(r_tail);
                    we      = accept;
                    waddr   = r_tail;
                    n_count = t_cnt'(r_count + 1'b1);
                    n_upd   = UPD_PUSH_B;
                end
            end
            MODE_POP_FRONT: begin
                if (!empty) begin
                    n_popped = r_front;
                    n_pop_ok = 1'b1;
                    n_head   = idx_next(r_head);
                    n_count  = t_cnt'(r_count - 1'b1);
                    re       = accept;
                    raddr    = idx_next(r_head);
                    n_upd    = UPD_POP_F;
                end
            end
            MODE_POP_BACK: begin
                if (!empty) begin
                    n_popped = r_back;
                    n_pop_ok = 1'b1;
                    n_tail   = idx_prev(r_tail);
                    n_count  = t_cnt'(r_count - 1'b1);
                    re       = accept;
                    // new back sits one before the new tail
                    raddr    = idx_prev(idx_prev(r_tail));
                    n_upd    = UPD_POP_B;
                end
            end
            default: begin
                // peek and unused codes leave the state alone
            end
        endcase
    end

    cdq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VAL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (in_val),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // execute state: new front and back; r_count already holds the new count
    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        case (r_upd)
            UPD_PUSH_F: begin
                n_front = r_val;
                if (r_count == t_cnt'(1)) begin
                    n_back = r_val;
                end
            end
            UPD_PUSH_B: begin
                n_back = r_val;
                if (r_count == t_cnt'(1)) begin
                    n_front = r_val;
                end
            end
            UPD_POP_F: begin
                n_front = (r_count == t_cnt'(1)) ? r_back : rd_data;
            end
            UPD_POP_B: begin
                n_back = (r_count == t_cnt'(1)) ? r_front : rd_data;
            end
            default: begin
            end
        endcase
    end

    assign out_empty = (r_count == '0);
    assign out_pack  = {out_empty ? NONE_VALUE : n_back,
                        out_empty ? NONE_VALUE : n_front,
                        out_empty, r_count, r_ovf, r_pop_ok, r_popped};
    assign exec_done = (r_state == S_EXEC) && (!r_m_valid || m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state  <= S_EXEC;
                r_head   <= n_head;
                r_tail   <= n_tail;
                r_count  <= n_count;
                r_upd    <= n_upd;
                r_val    <= in_val;
                r_pop_ok <= n_pop_ok;
                r_ovf    <= n_ovf;
                r_popped <= n_popped;
            end
            if (exec_done) begin
                r_state   <= S_IDLE;
                r_front   <= n_front;
                r_back    <= n_back;
                r_m_valid <= 1'b1;
                r_m_data  <= OUT_TDATA_W'(out_pack);
            end else if (r_m_valid && m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    // count never exceeds the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // an accepted request always moves the block into the execute state
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted request not in second cycle");

    // a result never reports both a pop and a dropped push
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !(r_m_data[VAL_W] && r_m_data[VAL_W+1]))
        else $error("pop_ok and overflow both set");

    // ram is never read and written in the same cycle
    a_ram_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we && re))
        else $error("ram read and write together");

    // a pop on a one-element deque leaves it empty with no read needed
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_pop_ok && (r_count == t_cnt'(1))) |=> (r_count == '0))
        else $error("last pop did not empty the deque");

endmodule

// ===== tb/sv/circular_deque_top_tb.sv =====
// self-checking testbench for the circular deque top level
`timescale 1ns / 100ps

module circular_deque_top_tb;
    import cdq_pkg::*;

    localparam int                 CLK_HALF    = 5;
    localparam int                 CYCLE_LIMIT = 500000;
    localparam int                 DRAIN_SLACK = 8;
    localparam int                 LONG_HOLD   = 300;
    // highest mode code; everything above peek behaves as peek
    localparam logic [MODE_W-1:0] MODE_TOP    = '1;

    // one result word, popped_value in the lowest bits
    typedef struct packed {
        t_val back_value;
        t_val front_value;
        logic is_empty;
        t_cnt element_count;
        logic overflow;
        logic pop_ok;
        t_val popped_value;
    } t_deque_result;

    // mirror of the deque contents plus the results still owed by the block
    class t_scoreboard;
        t_val          slot_mirror [CAPACITY];
        t_idx          head_slot;
        t_idx          tail_slot;
        t_cnt          depth_now;
        t_deque_result owed_results [$];
        int            mismatches;

        function new();
            head_slot  = '0;
            tail_slot  = '0;
            depth_now  = '0;
            mismatches = 0;
        endfunction

        // apply one accepted request to the mirror and queue what it must return
        function void note_request(logic [MODE_W-1:0] mode, t_val value);
            t_deque_result r;
            r.popped_value = NONE_VALUE;
            r.pop_ok       = 1'b0;
            r.overflow     = 1'b0;
            case (mode)
                MODE_PUSH_FRONT: begin
                    if (depth_now == CAPACITY) begin
                        r.overflow = 1'b1;
                    end else begin
                        head_slot              = head_slot - 1'b1;
                        slot_mirror[head_slot] = value;
                        depth_now++;
                    end
                end
                MODE_PUSH_BACK: begin
                    if (depth_now == CAPACITY) begin
                        r.overflow = 1'b1;
                    end else begin
                        slot_mirror[tail_slot] = value;
                        tail_slot              = tail_slot + 1'b1;
                        depth_now++;
                    end
                end
                MODE_POP_FRONT: begin
                    if (depth_now != 0) begin
                        r.popped_value = slot_mirror[head_slot];
                        r.pop_ok       = 1'b1;
                        head_slot      = head_slot + 1'b1;
                        depth_now--;
                    end
                end
                MODE_POP_BACK: begin
                    if (depth_now != 0) begin
                        tail_slot      = tail_slot - 1'b1;
                        r.popped_value = slot_mirror[tail_slot];
                        r.pop_ok       = 1'b1;
                        depth_now--;
                    end
                end
                default: begin
                end
            endcase
            r.element_count = depth_now;
            r.is_empty      = (depth_now == 0);
            r.front_value   = r.is_empty ? NONE_VALUE : slot_mirror[head_slot];
            r.back_value    = r.is_empty ? NONE_VALUE : slot_mirror[t_idx'(tail_slot - 1'b1)];
            owed_results.insert(owed_results.size(), r);
        endfunction

        function void compare(string field, logic [VAL_W-1:0] want_v, logic [VAL_W-1:0] got_v);
            if (got_v !== want_v) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %h actual %h",
                         $time, field, want_v, got_v);
            end
        endfunction

        // compare one accepted result word with the oldest owed result
        function void check_result(logic [OUT_TDATA_W-1:0] word);
            t_deque_result got;
            t_deque_result want;
            got = word[OUT_W-1:0];
            if (owed_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected, expected nothing actual %h",
                         $time, word);
                return;
            end
            want = owed_results[0];
            owed_results.delete(0);
            compare("popped_value",  want.popped_value,  got.popped_value);
            compare("pop_ok",        want.pop_ok,        got.pop_ok);
            compare("overflow",      want.overflow,      got.overflow);
            compare("element_count", want.element_count, got.element_count);
            compare("is_empty",      want.is_empty,      got.is_empty);
            compare("front_value",   want.front_value,   got.front_value);
            compare("back_value",    want.back_value,    got.back_value);
        endfunction
    endclass

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // bits from lsb: mode, push_value, zero pad
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // bits from lsb: popped_value, pop_ok, overflow, element_count, is_empty,
    // front_value, back_value, zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;

    t_scoreboard     ledger        = new();
    int              cycle_count   = 0;
    // knobs for the request source and the result sink
    bit              source_gaps_on = 1'b1;
    bit              sink_stalls_on = 1'b1;
    bit              hold_request   = 1'b0;

    circular_deque_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // run limit, generous against the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result sink: ready in random bursts, plus one long hold on demand
    initial begin : result_sink
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (gap_left > 0) begin
                m_tready <= 1'b0;
                gap_left--;
            end else begin
                m_tready <= 1'b1;
                if (sink_stalls_on && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 8);
            end
        end
    end

    // results are sampled at the rising edge, before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            ledger.check_result(m_tdata);
    end

    // offer one request, hold it until taken, then maybe leave a gap;
    // entered and left at a falling edge
    task automatic send_request(input logic [MODE_W-1:0] mode, input t_val value);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({value, mode});
        do @(posedge i_clk); while (!s_tready);
        ledger.note_request(mode, value);
        @(negedge i_clk);
        if (source_gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    endtask

    // stop offering until every owed result has come back
    task automatic wait_all_returned();
        s_tvalid <= 1'b0;
        while (ledger.owed_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // push values lean on the sign bit and all-ones / all-zeros patterns
    function automatic t_val pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(int push_pct, int pop_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return ($urandom_range(0, 1) != 0) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        if (r < push_pct + pop_pct)
            return ($urandom_range(0, 1) != 0) ? MODE_POP_BACK : MODE_POP_FRONT;
        if ($urandom_range(0, 3) == 0)
            return MODE_W'($urandom_range(int'(MODE_PEEK) + 1, int'(MODE_TOP)));
        return MODE_PEEK;
    endfunction

    task automatic send_random(int count, int push_pct, int pop_pct);
        repeat (count) send_request(pick_mode(push_pct, pop_pct), pick_value());
    endtask

    initial begin : stimulus
        int m;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-deque pops and peeks, every unused mode code
        send_request(MODE_POP_FRONT, 32'h1234_5678);
        send_request(MODE_POP_BACK,  32'h8765_4321);
        send_request(MODE_PEEK,      '0);
        for (m = MODE_PEEK + 1; m <= MODE_TOP; m++)
            send_request(MODE_W'(m), '1);
        // directed: extremes in from both ends, then taken out from both ends
        send_request(MODE_PUSH_FRONT, 32'h7fff_ffff);
        send_request(MODE_PUSH_BACK,  32'h8000_0000);
        send_request(MODE_PUSH_FRONT, '1);
        send_request(MODE_PUSH_BACK,  '0);
        send_request(MODE_PEEK,       32'hdead_beef);
        send_request(MODE_TOP,        32'h0bad_f00d);
        send_request(MODE_POP_BACK,   '0);
        send_request(MODE_POP_FRONT,  '0);
        send_request(MODE_POP_FRONT,  '0);
        send_request(MODE_POP_BACK,   '0);
        // single element: front and back are the same slot
        send_request(MODE_PUSH_BACK,  32'h5555_5555);
        send_request(MODE_POP_FRONT,  '0);
        send_request(MODE_PUSH_FRONT, 32'haaaa_aaaa);
        send_request(MODE_POP_BACK,   '0);
        send_request(MODE_POP_BACK,   '0);
        wait_all_returned();

        // mixed traffic around a small, often empty deque
        send_random(250, 50, 40);

        // long sink hold while the source keeps offering: block backs up
        source_gaps_on = 1'b0;
        hold_request   = 1'b1;
        send_random(30, 60, 30);
        source_gaps_on = 1'b1;

        // source pause until everything has come back
        wait_all_returned();

        // grow a deep deque with both pointers wrapped, then churn it
        send_random(300, 85, 10);
        send_random(200, 45, 45);
        wait_all_returned();

        // last stretch with neither side idling
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        send_random(150, 40, 50);

        wait_all_returned();
        repeat (DRAIN_SLACK) @(posedge i_clk);
        if (ledger.owed_results.size() != 0)
            $display("%0t: %0d results never arrived", $time, ledger.owed_results.size());

        if (ledger.mismatches == 0 && ledger.owed_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ram.sv
hw/rtl/circular_deque_top.sv
tb/sv/circular_deque_top_tb.sv
